// ----- hw/rtl/ssd_pkg.sv -----
// ----------------------------------------------------------------------------
// ssd_pkg
// shared types and constants for the session sequence duplicate filter
// ----------------------------------------------------------------------------
package ssd_pkg;

    // default ring depth and entry width
    localparam int WindowDepthDefault = 16;
    localparam int SessW              = 8;
    localparam int SeqW               = 8;
    localparam int PairW              = SessW + SeqW;

    // result codes
    typedef enum logic [1:0] {
        DEC_ACCEPT    = 2'd0,
        DEC_DUPLICATE = 2'd1,
        DEC_MISMATCH  = 2'd2
    } t_decision;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ----- hw/rtl/ssd_ram.sv -----
// ----------------------------------------------------------------------------
// ssd_ram
// ring storage of seen pairs, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ssd_ram #(
    parameter int DEPTH  = ssd_pkg::WindowDepthDefault,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DATA_W = ssd_pkg::PairW
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/session_sequence_dedup.sv -----
// ----------------------------------------------------------------------------
// session_sequence_dedup
// sliding window duplicate filter for received frame headers
// ----------------------------------------------------------------------------
// Each input transaction carries one frame header and yields exactly one
// output transaction with the decision (accept, duplicate or session
// mismatch). The last WINDOW_DEPTH (session, sequence) pairs sit in a
// single-port-read ring memory with a registered read; a header is
// checked by walking the filled part of the ring one entry per cycle. The walk
// ends early when a duplicate is found, and a session mismatch skips it. One
// header is processed at a time; a new header is taken as soon as the previous
// decision is in the output register, even if the downstream side has not yet
// taken it. No clearing pass is needed after reset: ring entries at or beyond
// the fill count are never compared.
// ----------------------------------------------------------------------------
module session_sequence_dedup #(
    parameter int WINDOW_DEPTH = ssd_pkg::WindowDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // header input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] session_number, [15:8] sequence_number
    input  logic        i_s_tuser,   // [0] is_start
    // decision output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [1:0] decision, [7:2] zero
);

    localparam int PtrW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CntW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CntW-1:0] FillMax = CntW'(WINDOW_DEPTH);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(WINDOW_DEPTH - 1);

    // session tracking and ring bookkeeping
    ssd_pkg::t_state            r_state, n_state;
    logic                       r_known, n_known;
    logic [ssd_pkg::SessW-1:0]  r_active, n_active;
    logic [PtrW-1:0]            r_ptr, n_ptr;
    logic [CntW-1:0]            r_fill, n_fill;

    // current header and walk position
    logic [ssd_pkg::PairW-1:0]  r_pair, n_pair;
    logic [CntW-1:0]            r_idx, n_idx;
    logic                       r_chk, n_chk;     // read data valid this cycle
    ssd_pkg::t_decision         r_dec, n_dec;

    // output register
    logic                       r_out_valid, n_out_valid;
    ssd_pkg::t_decision         r_out_dec, n_out_dec;

    // ring memory port
    logic                       wr_en;
    logic [PtrW-1:0]            rd_addr;
    logic [ssd_pkg::PairW-1:0]  rd_data;

    logic [ssd_pkg::SessW-1:0]  in_sess;
    logic [ssd_pkg::SeqW-1:0]   in_seq;
    logic                       in_fire;
    logic                       out_free;

    assign in_sess  = i_s_tdata[ssd_pkg::SessW-1:0];
    assign in_seq   = i_s_tdata[ssd_pkg::PairW-1:ssd_pkg::SessW];
    assign in_fire  = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    assign o_s_tready = (r_state == ssd_pkg::S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_dec};
    assign rd_addr    = r_idx[PtrW-1:0];

    ssd_ram #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (PtrW),
        .DATA_W (ssd_pkg::PairW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_ptr),
        .i_wr_data (r_pair),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssd_pkg::S_IDLE;
            r_known     <= 1'b0;
            r_active    <= '0;
            r_ptr       <= '0;
            r_fill      <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_known     <= n_known;
            r_active    <= n_active;
            r_ptr       <= n_ptr;
            r_fill      <= n_fill;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pair    <= n_pair;
        r_idx     <= n_idx;
        r_dec     <= n_dec;
        r_out_dec <= n_out_dec;
    end

    always_comb begin
        n_state     = r_state;
        n_known     = r_known;
        n_active    = r_active;
        n_ptr       = r_ptr;
        n_fill      = r_fill;
        n_pair      = r_pair;
        n_idx       = r_idx;
        n_chk       = 1'b0;
        n_dec       = r_dec;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_dec   = r_out_dec;
        wr_en       = 1'b0;

        unique case (r_state)
            ssd_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_pair = {in_sess, in_seq};
                    n_idx  = '0;
                    n_state = ssd_pkg::S_SCAN;
                    if (i_s_tuser) begin
                        // a start of a new session empties the window
                        if (!r_known || in_sess != r_active) begin
                            n_ptr  = '0;
                            n_fill = '0;
                        end
                        n_active = in_sess;
                        n_known  = 1'b1;
                    end else if (!r_known) begin
                        n_active = in_sess;
                        n_known  = 1'b1;
                    end else if (in_sess != r_active) begin
                        // foreign session, nothing recorded
                        n_dec   = ssd_pkg::DEC_MISMATCH;
                        n_state = ssd_pkg::S_DONE;
                    end
                end
            end

            ssd_pkg::S_SCAN: begin
                if (r_chk && rd_data == r_pair) begin
                    n_dec   = ssd_pkg::DEC_DUPLICATE;
                    n_state = ssd_pkg::S_DONE;
                end else if (r_idx < r_fill) begin
                    n_idx = r_idx + 1'b1;
                    n_chk = 1'b1;
                end else begin
                    // walk finished without a hit: record the pair
                    wr_en  = 1'b1;
                    n_ptr  = (r_ptr == PtrLast) ? '0 : r_ptr + 1'b1;
                    n_fill = (r_fill == FillMax) ? r_fill : r_fill + 1'b1;
                    n_dec  = ssd_pkg::DEC_ACCEPT;
                    n_state = ssd_pkg::S_DONE;
                end
            end

            ssd_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_dec   = r_dec;
                    n_state     = ssd_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ssd_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // fill count never exceeds the ring depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FillMax)
        else $error("fill count beyond ring depth");

    // until the ring wraps, the write pointer tracks the fill count
    a_ptr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill < FillMax) |-> (CntW'(r_ptr) == r_fill))
        else $error("write pointer out of step with fill count");

    // the walk index never runs beyond the fill count
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssd_pkg::S_SCAN) |-> (r_idx <= r_fill))
        else $error("ring walk beyond fill count");

    // an accept always grows the window or keeps it full
    a_accept_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_fill == FillMax) || (r_fill == $past(r_fill) + 1'b1))
        else $error("recorded pair not counted");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the session sequence duplicate filter
// ----------------------------------------------------------------------------
// Frame headers go in on the slave-side stream and each decision that comes
// back is compared with a behavioural model of the session and ring state
// that is kept inside the bench. A short directed part covers first-frame
// adoption, session mismatch, start frames of the same and of a new session,
// the field extremes and ring wraparound. It is followed by random session
// runs with sequence numbers drawn from narrow windows, so that duplicates and
// evictions are frequent, mixed with stray sessions and plain noise. The
// sender idles in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb;

    localparam int RingDepth   = ssd_pkg::WindowDepthDefault;
    localparam bit StartFrame  = 1'b1;
    localparam bit DataFrame   = 1'b0;
    localparam int DrainCycles = RingDepth + 8;
    localparam int ReportLimit = 20;

    // receiver behaviour, chosen again at random when each mode period ends
    typedef enum int {
        RX_OPEN,    // always ready
        RX_COIN,    // ready on a coin toss
        RX_SPARSE,  // ready one cycle in four
        RX_HELD     // mostly ready, with occasional long stalls
    } t_rx_mode;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;    // [7:0] session_number, [15:8] sequence_number
    logic        i_s_tuser  = 1'b0;  // [0] is_start
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;          // [1:0] decision, [7:2] zero

    // behavioural copy of the filter state
    logic                      model_known;
    logic [ssd_pkg::SessW-1:0] model_session;
    logic [ssd_pkg::PairW-1:0] model_ring [RingDepth];
    int unsigned               model_wptr;
    int unsigned               model_fill;

    // decisions still owed by the block, oldest first
    ssd_pkg::t_decision pending_decisions [$];
    int unsigned mismatch_count = 0;
    int unsigned burst_left     = 0;

    t_rx_mode    rx_mode    = RX_OPEN;
    int unsigned mode_left  = 0;
    int unsigned stall_left = 0;

    session_sequence_dedup #(
        .WINDOW_DEPTH(RingDepth)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // works out the decision for one header and advances the model state
    function automatic ssd_pkg::t_decision judge_header(bit start, logic [7:0] sess,
                                                        logic [7:0] seq);
        logic [ssd_pkg::PairW-1:0] pair;
        pair = {sess, seq};
        if (start) begin
            // a start frame of a new session throws the window away
            if (!model_known || sess != model_session) begin
                model_wptr = 0;
                model_fill = 0;
            end
            model_session = sess;
            model_known   = 1'b1;
        end else if (!model_known) begin
            // very first frame adopts its session whatever its kind
            model_session = sess;
            model_known   = 1'b1;
        end else if (sess != model_session) begin
            // stray session, nothing recorded
            return ssd_pkg::DEC_MISMATCH;
        end
        // only the filled part of the ring is ever looked at
        for (int i = 0; i < model_fill; i++) begin
            if (model_ring[i] == pair) begin
                return ssd_pkg::DEC_DUPLICATE;
            end
        end
        model_ring[model_wptr] = pair;
        model_wptr = (model_wptr + 1) % RingDepth;
        if (model_fill < RingDepth) begin
            model_fill++;
        end
        return ssd_pkg::DEC_ACCEPT;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatch_count < ReportLimit) begin
            $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // drives one header transaction, idling between bursts, and records
    // the decision it is owed once the block takes it
    task automatic send_header(bit start, logic [7:0] sess, logic [7:0] seq);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= start;
        i_s_tdata  <= {seq, sess};
        do @(posedge i_clk); while (!o_s_tready);
        pending_decisions.push_back(judge_header(start, sess, seq));
        @(negedge i_clk);
    endtask

    // downstream stall pattern
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        case (rx_mode)
            RX_OPEN: begin
                i_m_tready <= 1'b1;
            end
            RX_COIN: begin
                i_m_tready <= 1'($urandom);
            end
            RX_SPARSE: begin
                i_m_tready <= (mode_left % 4 == 0);
            end
            default: begin
                if (stall_left == 0 && $urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(5, 40);
                end
                if (stall_left > 0) begin
                    stall_left--;
                    i_m_tready <= 1'b0;
                end else begin
                    i_m_tready <= 1'b1;
                end
            end
        endcase
    end

    // compares every decision transaction with the oldest one owed and checks its padding bits
    always @(posedge i_clk) begin
        ssd_pkg::t_decision want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_decisions.size() == 0) begin
                report_mismatch("decision with none pending", o_m_tdata[1:0], 0);
            end else begin
                want = pending_decisions.pop_front();
                if (o_m_tdata[1:0] != want) begin
                    report_mismatch("decision", o_m_tdata[1:0], want);
                end
            end
            if (o_m_tdata[7:2] != '0) begin
                report_mismatch("padding bits", o_m_tdata[7:2], 0);
            end
        end
    end

    // first frame adopts its session even without the start flag
    task automatic test_first_frame();
        send_header(DataFrame, 8'hFF, 8'h00);
        send_header(DataFrame, 8'hFF, 8'h00);
    endtask

    // frames of another session without the start flag are refused
    task automatic test_session_mismatch();
        send_header(DataFrame, 8'h00, 8'h00);
        send_header(DataFrame, 8'h00, 8'hFF);
    endtask

    // start of the same session keeps the window, a new session clears it
    task automatic test_session_start();
        send_header(StartFrame, 8'hFF, 8'h00);
        send_header(StartFrame, 8'h00, 8'hFF);
        send_header(DataFrame, 8'h00, 8'hFF);
    endtask

    // overfill the ring so that the oldest pair drops out
    task automatic test_ring_wraparound();
        for (int s = 0; s < RingDepth; s++) begin
            send_header(DataFrame, 8'h00, 8'(s));
        end
        send_header(DataFrame, 8'h00, 8'hFF);
        send_header(DataFrame, 8'h00, 8'(RingDepth - 1));
    endtask

    // session runs with narrow sequence windows, plus strays and noise
    task automatic test_random_traffic(int unsigned target);
        logic [7:0]  favourites [4];
        logic [7:0]  sess;
        logic [7:0]  base;
        int unsigned sent;
        int unsigned run_len;
        int unsigned span;
        int unsigned pick;
        favourites = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                sess    = ($urandom_range(0, 9) < 7) ? favourites[$urandom_range(0, 3)]
                                                     : 8'($urandom);
                base    = 8'($urandom);
                span    = $urandom_range(3, 40);
                run_len = $urandom_range(5, 40);
                if ($urandom_range(0, 4) != 0) begin
                    send_header(StartFrame, sess, base + 8'($urandom_range(0, span)));
                    sent++;
                end
                repeat (run_len) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 5) begin
                        send_header(DataFrame, 8'($urandom), 8'($urandom));
                    end else if (pick < 10) begin
                        send_header(StartFrame, sess, base + 8'($urandom_range(0, span)));
                    end else begin
                        send_header(DataFrame, sess, base + 8'($urandom_range(0, span)));
                    end
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 10)) begin
                    send_header(1'($urandom), 8'($urandom), 8'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        model_known   = 1'b0;
        model_session = '0;
        model_wptr    = 0;
        model_fill    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_frame();
        test_session_mismatch();
        test_session_start();
        test_ring_wraparound();
        test_random_traffic(1750);

        i_s_tvalid <= 1'b0;
        while (pending_decisions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
